// ===== hw/rtl/odo_pkg.sv =====
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types and constants of the omni-drive odometry block.
// ----------------------------------------------------------------------------
`default_nettype none

package odo_pkg;

  localparam int unsigned MaxCordicSteps = 24;
  localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;
  localparam logic [15:0] TimeStepReset = 16'd655;

  typedef enum logic {
    ReqLoad = 1'b0,
    ReqTick = 1'b1
  } req_type_e;

  typedef struct packed {
    logic              req_type;
    logic [3:0]        coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] wheel_speed_0;
    logic signed [31:0] wheel_speed_1;
    logic signed [31:0] wheel_speed_2;
    logic signed [31:0] wheel_speed_3;
    logic [15:0]       heading;
  } odo_req_t;

  typedef struct packed {
    logic signed [31:0] vel_x_world;
    logic signed [31:0] vel_y_world;
    logic signed [31:0] rot_rate;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_angle;
  } odo_rsp_t;

  // Control between sequencer and CORDIC unit.
  typedef struct packed {
    logic        start;
    logic [15:0] heading;
  } odo_cordic_cmd_t;

  typedef struct packed {
    logic               done;
    logic signed [33:0] cos_val;
    logic signed [33:0] sin_val;
  } odo_cordic_rsp_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0:  atan_lut = 32'd536870912;
      5'd1:  atan_lut = 32'd316933406;
      5'd2:  atan_lut = 32'd167458907;
      5'd3:  atan_lut = 32'd85004756;
      5'd4:  atan_lut = 32'd42667331;
      5'd5:  atan_lut = 32'd21354465;
      5'd6:  atan_lut = 32'd10679838;
      5'd7:  atan_lut = 32'd5340245;
      5'd8:  atan_lut = 32'd2670163;
      5'd9:  atan_lut = 32'd1335087;
      5'd10: atan_lut = 32'd667544;
      5'd11: atan_lut = 32'd333772;
      5'd12: atan_lut = 32'd166886;
      5'd13: atan_lut = 32'd83443;
      5'd14: atan_lut = 32'd41722;
      5'd15: atan_lut = 32'd20861;
      5'd16: atan_lut = 32'd10430;
      5'd17: atan_lut = 32'd5215;
      5'd18: atan_lut = 32'd2608;
      5'd19: atan_lut = 32'd1304;
      5'd20: atan_lut = 32'd652;
      5'd21: atan_lut = 32'd326;
      5'd22: atan_lut = 32'd163;
      5'd23: atan_lut = 32'd81;
      default: atan_lut = 32'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/odo_if.sv =====
// ----------------------------------------------------------------------------
// odo_req_if / odo_rsp_if / odo_cfg_if
// Valid/ready channels of the odometry block.
// ----------------------------------------------------------------------------
`default_nettype none

interface odo_req_if;
  import odo_pkg::*;
  logic     valid;
  logic     ready;
  odo_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface odo_rsp_if;
  import odo_pkg::*;
  logic     valid;
  logic     ready;
  odo_rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface odo_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/odo_cordic.sv =====
// ----------------------------------------------------------------------------
// odo_cordic
// Iterative CORDIC: cosine and sine of a binary angle in Q4.30, one
// rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_cordic #(
  parameter int unsigned CordicSteps = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire odo_pkg::odo_cordic_cmd_t  cmd_i,
  output odo_pkg::odo_cordic_rsp_t       rsp_o
);
  import odo_pkg::*;

  localparam int unsigned Steps = (CordicSteps < MaxCordicSteps) ? CordicSteps : MaxCordicSteps;

  logic               busy_q;
  logic               done_q;
  logic               flip_q;
  logic [4:0]         step_q;
  logic signed [33:0] x_q, y_q;
  logic signed [32:0] z_q;
  logic [31:0]        theta;
  logic [31:0]        theta_r;
  logic               flip;
  logic signed [33:0] xs, ys;
  logic signed [32:0] at;

  always_comb begin
    theta   = {cmd_i.heading, 16'd0};
    flip    = theta[31] ^ theta[30];
    theta_r = flip ? (theta + 32'h8000_0000) : theta;
    xs      = x_q >>> step_q;
    ys      = y_q >>> step_q;
    at      = {1'b0, atan_lut(step_q)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == 5'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q    <= CordicGainQ30;
      y_q    <= '0;
      z_q    <= {theta_r[31], theta_r};
      flip_q <= flip;
    end else if (busy_q) begin
      if (!z_q[32]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.cos_val = flip_q ? -x_q : x_q;
  assign rsp_o.sin_val = flip_q ? -y_q : y_q;

endmodule

`default_nettype wire

// ===== hw/rtl/omni_drive_odometry_top.sv =====
// ----------------------------------------------------------------------------
// omni_drive_odometry_top
// Omni-wheel odometry: coefficient table, shared MAC, CORDIC, pose integrator.
// ----------------------------------------------------------------------------
// A load item writes one table entry when its index lies inside the table, and
// the block stays idle for the next item. For a tick, one shared multiplier
// runs the 3*NumWheels coefficient products, each in three steps (table read,
// multiply, accumulate). The CORDIC unit is then started and does one rotation
// per cycle until it signals done. The same multiplier does the four rotation
// products and the three pose steps, each as a multiply and an accumulate.
// StOut then loads the output register and the block returns to idle to take
// the next item. The result waits in the output register, so the block keeps
// taking items while it waits. A finished tick stalls in StOut until the
// previous result has been accepted.
`default_nettype none

module omni_drive_odometry_top #(
  parameter int unsigned NumWheels   = 4,
  parameter int unsigned CordicSteps = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  odo_req_if.sink   req,
  odo_rsp_if.source rsp,
  odo_cfg_if.sink   cfg
);
  import odo_pkg::*;

  localparam int unsigned TableSize = 3 * NumWheels;
  localparam int unsigned IdxW      = $clog2(TableSize);
  localparam int unsigned WheelW    = $clog2(NumWheels);

  typedef enum logic [3:0] {
    StIdle, StMac, StMacAcc, StCordic, StRot, StRotAcc, StPos, StPosAcc, StOut
  } state_e;

  state_e             state_q;
  logic [15:0]        time_step_q;
  logic [31:0]        coef_mem [TableSize];
  logic [IdxW-1:0]    idx_q;
  logic [WheelW-1:0]  wheel_q;
  logic [1:0]         row_q;
  logic [2:0]         sub_q;
  logic signed [31:0] spd_q [4];
  logic [15:0]        heading_q;
  logic signed [31:0] coef_rd_q;
  logic signed [63:0] prod_q;
  logic signed [49:0] sum_q [3];
  logic signed [31:0] vr_q [3];
  logic signed [33:0] cos_q, sin_q;
  logic signed [66:0] rot_acc_q;
  logic signed [31:0] wx_q, wy_q;
  logic signed [31:0] acc_x_q, acc_y_q, acc_a_q;
  logic               rsp_valid_q;
  odo_rsp_t           rsp_q;

  odo_cordic_cmd_t cord_cmd;
  odo_cordic_rsp_t cord_rsp;

  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] mul_p;
  logic signed [31:0] cur_spd;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) sat32 = 32'sh7fff_ffff;
    else if (v < -68'sd2147483648) sat32 = 32'sh8000_0000;
    else sat32 = v[31:0];
  endfunction

  odo_cordic #(.CordicSteps(CordicSteps)) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cord_cmd),
    .rsp_o (cord_rsp)
  );

  assign cord_cmd.start   = (state_q == StCordic) && (sub_q == 3'd0);
  assign cord_cmd.heading = heading_q;

  // Wheels beyond the four speed inputs count with speed zero.
  assign cur_spd = (32'(wheel_q) < 32'd4) ? spd_q[wheel_q[1:0]] : 32'sd0;

  // Shared multiplier operand select.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StMac: begin
        mul_a = 34'(coef_rd_q);
        mul_b = 34'(cur_spd);
      end
      StRot: begin
        case (sub_q[1:0])
          2'd0:    begin mul_a = 34'(vr_q[0]); mul_b = cos_q; end
          2'd1:    begin mul_a = 34'(vr_q[1]); mul_b = -sin_q; end
          2'd2:    begin mul_a = 34'(vr_q[0]); mul_b = sin_q; end
          default: begin mul_a = 34'(vr_q[1]); mul_b = cos_q; end
        endcase
      end
      StPos: begin
        case (sub_q[1:0])
          2'd0:    mul_a = 34'(wx_q);
          2'd1:    mul_a = 34'(wy_q);
          default: mul_a = 34'(vr_q[2]);
        endcase
        mul_b = 34'($signed({1'b0, time_step_q}));
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  logic signed [67:0] rnd16;
  logic signed [67:0] rnd30;
  logic signed [67:0] pos_sum;
  logic signed [31:0] pos_old;
  always_comb begin
    rnd16 = (68'(prod_q) + 68'sd32768) >>> 16;
    rnd30 = (68'(rot_acc_q) + 68'sd536870912) >>> 30;
    case (sub_q[1:0])
      2'd0:    pos_old = acc_x_q;
      2'd1:    pos_old = acc_y_q;
      default: pos_old = acc_a_q;
    endcase
    pos_sum = 68'(pos_old) + rnd16;
  end

  assign req.ready = (state_q == StIdle);
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid_q;
  assign rsp.payload = rsp_q;

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready && req.payload.req_type == ReqLoad &&
        32'(req.payload.coef_index) < TableSize) begin
      coef_mem[IdxW'(req.payload.coef_index)] <= req.payload.coef_value;
    end
    coef_rd_q <= coef_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      time_step_q <= TimeStepReset;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      acc_a_q     <= '0;
      idx_q       <= '0;
      wheel_q     <= '0;
      row_q       <= '0;
      sub_q       <= '0;
    end else begin
      if (cfg.valid) time_step_q <= cfg.data;
      if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (req.valid && req.ready && req.payload.req_type == ReqTick) begin
            spd_q[0]  <= req.payload.wheel_speed_0;
            spd_q[1]  <= req.payload.wheel_speed_1;
            spd_q[2]  <= req.payload.wheel_speed_2;
            spd_q[3]  <= req.payload.wheel_speed_3;
            heading_q <= req.payload.heading;
            for (int r = 0; r < 3; r++) sum_q[r] <= '0;
            idx_q     <= '0;
            row_q     <= '0;
            wheel_q   <= '0;
            sub_q     <= '0;
            state_q   <= StMacAcc;
          end
        end
        // With sub_q zero, a wait cycle: table read data lands in coef_rd_q; else accumulate.
        StMacAcc: begin
          if (sub_q != 3'd0) begin
            sum_q[row_q] <= sum_q[row_q] + 50'(rnd16);
            if (32'(idx_q) == TableSize - 1) begin
              state_q <= StCordic;
              sub_q   <= '0;
            end else begin
              idx_q <= idx_q + 1'b1;
              if (32'(wheel_q) == NumWheels - 1) begin
                wheel_q <= '0;
                row_q   <= row_q + 2'd1;
              end else begin
                wheel_q <= wheel_q + 1'b1;
              end
              state_q <= StMacAcc;
              sub_q   <= '0;
            end
          end else begin
            state_q <= StMac;
          end
        end
        StMac: begin
          prod_q  <= 64'(mul_p);
          sub_q   <= 3'd1;
          state_q <= StMacAcc;
        end
        StCordic: begin
          if (sub_q == 3'd0) begin
            for (int r = 0; r < 3; r++) vr_q[r] <= sat32(68'(sum_q[r]));
            sub_q <= 3'd1;
          end else if (cord_rsp.done) begin
            cos_q     <= cord_rsp.cos_val;
            sin_q     <= cord_rsp.sin_val;
            rot_acc_q <= '0;
            sub_q     <= '0;
            state_q   <= StRot;
          end
        end
        StRot: begin
          prod_q    <= mul_p[63:0];
          rot_acc_q <= rot_acc_q + 67'(mul_p);
          state_q   <= StRotAcc;
        end
        StRotAcc: begin
          if (sub_q[0]) begin
            if (sub_q[1]) wy_q <= sat32(rnd30);
            else          wx_q <= sat32(rnd30);
            rot_acc_q <= '0;
          end
          if (sub_q == 3'd3) begin
            sub_q   <= '0;
            state_q <= StPos;
          end else begin
            sub_q   <= sub_q + 3'd1;
            state_q <= StRot;
          end
        end
        StPos: begin
          prod_q  <= mul_p[63:0];
          state_q <= StPosAcc;
        end
        StPosAcc: begin
          case (sub_q[1:0])
            2'd0:    acc_x_q <= sat32(pos_sum);
            2'd1:    acc_y_q <= sat32(pos_sum);
            default: acc_a_q <= sat32(pos_sum);
          endcase
          if (sub_q == 3'd2) begin
            state_q <= StOut;
          end else begin
            sub_q   <= sub_q + 3'd1;
            state_q <= StPos;
          end
        end
        // Hold until the output register is free or its result is being accepted.
        StOut: begin
          if (!rsp_valid_q || rsp.ready) begin
            rsp_q.vel_x_world <= wx_q;
            rsp_q.vel_y_world <= wy_q;
            rsp_q.rot_rate    <= vr_q[2];
            rsp_q.pos_x       <= acc_x_q;
            rsp_q.pos_y       <= acc_y_q;
            rsp_q.pos_angle   <= acc_a_q;
            rsp_valid_q       <= 1'b1;
            state_q           <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Multiplication products must be full-precision: coefficient products fit 64 bits.
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !req.ready) else $error("ready while busy");
  a_out_after_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == StOut) else $error("result out of sequence");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp.ready |=> rsp_valid_q && $stable(rsp_q))
    else $error("result dropped");

endmodule

`default_nettype wire

// ===== verif/odo_tb_if.sv =====
// ----------------------------------------------------------------------------
// odo_tb_if
// Interface instances used by the odometry testbench are the RTL interfaces;
// this file holds the stimulus row type used by the testbench top.
// ----------------------------------------------------------------------------
package odo_tb_pkg;
  import odo_pkg::*;

  typedef struct {
    odo_req_t req;
    bit       has_exp;
    odo_rsp_t exp;
  } stim_row_t;
endpackage

// ===== verif/omni_drive_odometry_top_tb.sv =====
// ----------------------------------------------------------------------------
// omni_drive_odometry_top_tb
// Coefficient loads, odometry ticks and time-step writes against a predictor
// of the MAC, CORDIC rotation and saturating pose integration.
// ----------------------------------------------------------------------------
module omni_drive_odometry_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import odo_pkg::*;
  import odo_tb_pkg::*;

  localparam int NWHEEL = 4;
  localparam int NSTEP = 16;
  localparam int TBL = 3 * NWHEEL;
  localparam longint S32MAX = 64'sd2147483647;
  localparam longint S32MIN = -64'sd2147483648;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  odo_req_if req ();
  odo_rsp_if rsp ();
  odo_cfg_if cfg ();

  omni_drive_odometry_top #(.NumWheels(NWHEEL), .CordicSteps(NSTEP)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  // predictor state
  longint coef_mem[TBL];
  longint pose_x, pose_y, pose_th;
  longint dt_reg;
  odo_rsp_t pose_q[$];
  int errors = 0;
  bit quiet = 0;       // no idling near the end
  bit hold_rsp = 0;    // long receiver hold-off
  longint unsigned cycles = 0;

  function automatic longint asr64(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint rnd(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint sat(longint v);
    if (v > S32MAX) return S32MAX;
    if (v < S32MIN) return S32MIN;
    return v;
  endfunction

  function automatic longint atan_q30(int i);
    longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772,
                      166886, 83443, 41722, 20861, 10430, 5215,
                      2608, 1304, 652, 326, 163, 81};
    return t[i];
  endfunction

  task automatic sincos(input logic [15:0] hd, output longint c, output longint s);
    logic [31:0] th;
    bit flip;
    longint x, y, z, xs, ys;
    th = {hd, 16'h0};
    flip = (th[31:30] == 2'd1) || (th[31:30] == 2'd2);
    if (flip) th = th + 32'h8000_0000;
    x = 652032874;
    y = 0;
    z = longint'($signed(th));
    for (int i = 0; i < NSTEP && i < 24; i++) begin
      xs = asr64(x, i);
      ys = asr64(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_q30(i);
      end else begin
        x += ys; y -= xs; z += atan_q30(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Apply an accepted item to the predictor; queue a pose if it is a tick.
  task automatic predict_odometry(input odo_req_t r);
    longint acc[3], vr[3], spd[NWHEEL], c, s, wx, wy;
    odo_rsp_t o;
    if (r.req_type == ReqLoad) begin
      if (r.coef_index < TBL) coef_mem[r.coef_index] = longint'(r.coef_value);
      return;
    end
    spd[0] = r.wheel_speed_0; spd[1] = r.wheel_speed_1;
    spd[2] = r.wheel_speed_2; spd[3] = r.wheel_speed_3;
    for (int k = 0; k < 3; k++) acc[k] = 0;
    for (int j = 0; j < NWHEEL; j++)
      for (int k = 0; k < 3; k++) acc[k] += rnd(coef_mem[k * NWHEEL + j] * spd[j], 16);
    for (int k = 0; k < 3; k++) vr[k] = sat(acc[k]);
    sincos(r.heading, c, s);
    wx = sat(rnd(vr[0] * c - vr[1] * s, 30));
    wy = sat(rnd(vr[0] * s + vr[1] * c, 30));
    pose_x = sat(pose_x + rnd(wx * dt_reg, 16));
    pose_y = sat(pose_y + rnd(wy * dt_reg, 16));
    pose_th = sat(pose_th + rnd(vr[2] * dt_reg, 16));
    o.vel_x_world = wx[31:0]; o.vel_y_world = wy[31:0]; o.rot_rate = vr[2][31:0];
    o.pos_x = pose_x[31:0]; o.pos_y = pose_y[31:0]; o.pos_angle = pose_th[31:0];
    pose_q.push_back(o);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
    errors++;
  endtask

  // response side: random stalls, a long hold-off on request
  initial begin
    rsp.ready = 1'b0;
  end
  always @(posedge clk_i) begin
    if (hold_rsp) rsp.ready <= 1'b0;
    else if (quiet) rsp.ready <= 1'b1;
    else if (!rsp.ready) rsp.ready <= ($urandom_range(0, 2) == 0) ? 1'b0 : 1'b1;
    else rsp.ready <= ($urandom_range(0, 5) != 0);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pose_q.size() == 0) begin
        $display("unexpected pose item");
        errors++;
      end else begin
        odo_rsp_t e, g;
        e = pose_q.pop_front();
        g = rsp.payload;
        if (g.vel_x_world !== e.vel_x_world) report("vel_x", g.vel_x_world, e.vel_x_world);
        if (g.vel_y_world !== e.vel_y_world) report("vel_y", g.vel_y_world, e.vel_y_world);
        if (g.rot_rate !== e.rot_rate) report("rot_rate", g.rot_rate, e.rot_rate);
        if (g.pos_x !== e.pos_x) report("pos_x", g.pos_x, e.pos_x);
        if (g.pos_y !== e.pos_y) report("pos_y", g.pos_y, e.pos_y);
        if (g.pos_angle !== e.pos_angle) report("pos_angle", g.pos_angle, e.pos_angle);
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > 64'd400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input odo_req_t r, input bit may_idle);
    int gap;
    if (may_idle && !quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.payload <= r;
    do @(posedge clk_i); while (!req.ready);
    predict_odometry(r);
  endtask

  task automatic write_step(input logic [15:0] v);
    req.valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    dt_reg = v;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 4) - 2;
      3: return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic odo_req_t mk_load(input int idx, input logic [31:0] val);
    odo_req_t r;
    r = '{default: '0};
    r.req_type = ReqLoad;
    r.coef_index = 4'(idx);
    r.coef_value = val;
    r.wheel_speed_0 = $urandom;
    r.heading = 16'($urandom);
    return r;
  endfunction

  function automatic odo_req_t mk_tick(input logic [31:0] w0, w1, w2, w3,
                                       input logic [15:0] hd);
    odo_req_t r;
    r = '{default: '0};
    r.req_type = ReqTick;
    r.coef_index = 4'($urandom);
    r.coef_value = $urandom;
    r.wheel_speed_0 = w0; r.wheel_speed_1 = w1;
    r.wheel_speed_2 = w2; r.wheel_speed_3 = w3;
    r.heading = hd;
    return r;
  endfunction

  stim_row_t rows[$];

  initial begin
    odo_req_t r;
    stim_row_t row;
    int n;
    req.valid = 1'b0;
    req.payload = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    for (int i = 0; i < TBL; i++) coef_mem[i] = 0;
    pose_x = 0; pose_y = 0; pose_th = 0;
    dt_reg = TimeStepReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: unit identity-like table, then extremes
    for (int i = 0; i < TBL; i++) begin
      row.req = mk_load(i, (i % NWHEEL == i / NWHEEL) ? 32'h0001_0000 : 32'h0);
      row.has_exp = 0;
      rows.push_back(row);
    end
    row.req = mk_load(12, 32'h7fff_ffff); row.has_exp = 0; rows.push_back(row);
    row.req = mk_load(15, 32'h8000_0000); row.has_exp = 0; rows.push_back(row);
    // zero speeds at reset pose: everything zero
    row.req = mk_tick(0, 0, 0, 0, 16'h0); row.has_exp = 1; row.exp = '0; rows.push_back(row);
    row.has_exp = 0;
    row.req = mk_tick(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 16'h0);
    rows.push_back(row);
    row.req = mk_tick(32'h0001_0000, 0, 0, 0, 16'h4000); rows.push_back(row);
    row.req = mk_tick(32'h0001_0000, 0, 0, 0, 16'h8000); rows.push_back(row);
    row.req = mk_tick(32'h0001_0000, 0, 0, 0, 16'hc000); rows.push_back(row);
    row.req = mk_tick(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'hffff);
    rows.push_back(row);
    row.req = mk_tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h3fff);
    rows.push_back(row);

    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        send_item(rows[i].req, 1);
        // typed-in expectation must agree with the predictor
        if (pose_q[$] !== rows[i].exp) report("table row", i, 0);
      end else send_item(rows[i].req, 1);
    end

    write_step(16'hffff);
    // saturate the pose with large coefficients
    for (int i = 0; i < TBL; i++) send_item(mk_load(i, 32'h7fff_ffff), 1);
    repeat (6) send_item(mk_tick(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                 32'h7fff_ffff, 16'($urandom)), 1);
    write_step(16'd0);
    repeat (3) send_item(mk_tick(rand_word(), rand_word(), rand_word(), rand_word(),
                                 16'($urandom)), 1);
    write_step(16'd1);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_rsp = 1;
        repeat (300) @(posedge clk_i);
        hold_rsp = 0;
      end
      repeat (5) send_item(mk_tick(rand_word(), rand_word(), rand_word(), rand_word(),
                                   16'($urandom)), 0);
    join

    n = 0;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 1) write_step(16'($urandom_range(1, 65535)));
      if (ph == 2) write_step(16'd655);
      if (ph == 3) quiet = 1;
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 3) == 0) send_item(mk_load($urandom_range(0, 15), rand_word()), 1);
        else send_item(mk_tick(rand_word(), rand_word(), rand_word(), rand_word(),
                               16'($urandom)), 1);
      end
    end
    req.valid <= 1'b0;

    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
